### hw/rtl/slx_pkg.sv
package slx_pkg;

  // Longest stored text count that a command can carry (MAX_TEXT up to 63).
  localparam int LEN_W = 6;
  localparam int LINE_OUT_W = 16;
  localparam int QDEPTH = 2;

  typedef enum logic [3:0] {
    TOK_EXIT    = 4'd0,
    TOK_INT     = 4'd1,
    TOK_IDENT   = 4'd2,
    TOK_LITERAL = 4'd3,
    TOK_PLUS    = 4'd4,
    TOK_MINUS   = 4'd5,
    TOK_STAR    = 4'd6,
    TOK_SLASH   = 4'd7,
    TOK_PERCENT = 4'd8,
    TOK_LPAREN  = 4'd9,
    TOK_RPAREN  = 4'd10,
    TOK_SEMI    = 4'd11
  } tok_type_e;

  localparam logic KIND_HEAD = 1'b0;
  localparam logic KIND_TEXT = 1'b1;

  localparam logic ACT_CHAR = 1'b0;
  localparam logic ACT_END  = 1'b1;

  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_SEMI    = 8'h3B;

  // One queue entry: an optional name or literal token followed by an
  // optional operator token, both reported on the same line.
  typedef struct packed {
    logic                    has_tok;
    tok_type_e               tok_type;
    logic [LEN_W-1:0]        tok_len;
    logic                    trunc;
    logic                    bank;
    logic                    has_op;
    tok_type_e               op_type;
    logic [LINE_OUT_W-1:0]   line;
  } cmd_t;

  typedef struct packed {
    logic valid;
    logic bank;
  } rel_t;

  function automatic logic is_letter(input logic [7:0] c);
    return c inside {[8'h41:8'h5A], [8'h61:8'h7A]};
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_op(input logic [7:0] c);
    return c inside {CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_PERCENT,
                     CH_LPAREN, CH_RPAREN, CH_SEMI};
  endfunction

  function automatic tok_type_e op_type(input logic [7:0] c);
    tok_type_e t;
    case (c)
      CH_PLUS:    t = TOK_PLUS;
      CH_MINUS:   t = TOK_MINUS;
      CH_STAR:    t = TOK_STAR;
      CH_SLASH:   t = TOK_SLASH;
      CH_PERCENT: t = TOK_PERCENT;
      CH_LPAREN:  t = TOK_LPAREN;
      CH_RPAREN:  t = TOK_RPAREN;
      default:    t = TOK_SEMI;
    endcase
    return t;
  endfunction

  function automatic logic [7:0] kw_exit_char(input logic [1:0] pos);
    logic [7:0] ch;
    case (pos)
      2'd0:    ch = 8'h65;
      2'd1:    ch = 8'h78;
      2'd2:    ch = 8'h69;
      default: ch = 8'h74;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] kw_int_char(input logic [1:0] pos);
    logic [7:0] ch;
    case (pos)
      2'd0:    ch = 8'h69;
      2'd1:    ch = 8'h6E;
      default: ch = 8'h74;
    endcase
    return ch;
  endfunction

endpackage

### hw/rtl/source_lexer_top.sv
// Front end takes one source byte per cycle while in_ready_o is high (not when the queue
// is full or a text bank it needs is still being read out); a byte that only extends a
// name or literal produces nothing. Back end pops a queue entry, then sends the token
// head, each text byte after a registered RAM read, and the operator head, if present.
// Two text banks let a new token fill while the previous one is still read out.
// Asynchronous active-low reset empties the queue and returns the scanner to idle, line 0.
module source_lexer_top #(
  parameter int MAX_TEXT  = 16,
  parameter int LINE_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        action_i,
  input  logic [7:0]  character_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        kind_o,
  output logic [3:0]  token_type_o,
  output logic [15:0] line_number_o,
  output logic [4:0]  text_length_o,
  output logic        truncated_o,
  output logic [7:0]  text_char_o,
  output logic        last_o
);
  import slx_pkg::*;

  localparam int AW = $clog2(MAX_TEXT) + 1;

  cmd_t          q_wdata, q_rdata;
  logic          q_push, q_pop, q_full, q_empty;
  rel_t          rel;
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_wdata, ram_rdata;

  slx_front #(
    .MAX_TEXT (MAX_TEXT),
    .LINE_BITS(LINE_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .action_i   (action_i),
    .character_i(character_i),
    .rel_i      (rel),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_data_o   (q_wdata),
    .ram_we_o   (ram_we),
    .ram_waddr_o(ram_waddr),
    .ram_wdata_o(ram_wdata)
  );

  slx_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (q_wdata),
    .pop_i  (q_pop),
    .data_o (q_rdata),
    .full_o (q_full),
    .empty_o(q_empty)
  );

  slx_ram #(
    .WIDTH(8),
    .DEPTH(2 ** AW)
  ) u_text_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  slx_back #(
    .MAX_TEXT(MAX_TEXT)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_empty_i    (q_empty),
    .q_data_i     (q_rdata),
    .q_pop_o      (q_pop),
    .ram_re_o     (ram_re),
    .ram_raddr_o  (ram_raddr),
    .ram_rdata_i  (ram_rdata),
    .rel_o        (rel),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .kind_o       (kind_o),
    .token_type_o (token_type_o),
    .line_number_o(line_number_o),
    .text_length_o(text_length_o),
    .truncated_o  (truncated_o),
    .text_char_o  (text_char_o),
    .last_o       (last_o)
  );

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full) else $error("command queue overrun");

  a_no_pop_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty) else $error("command queue underrun");

  a_text_follows_name: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (kind_o == KIND_TEXT)) |->
      ((token_type_o == TOK_IDENT) || (token_type_o == TOK_LITERAL)))
    else $error("text byte attached to a token without text");

  a_op_has_no_text: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (kind_o == KIND_HEAD) && (token_type_o != TOK_IDENT) &&
     (token_type_o != TOK_LITERAL)) |-> ((text_length_o == '0) && !truncated_o))
    else $error("keyword or operator head carries text length");

endmodule

### hw/rtl/slx_ram.sv
module slx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/slx_queue.sv
module slx_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  slx_pkg::cmd_t data_i,
  input  logic          pop_i,
  output slx_pkg::cmd_t data_o,
  output logic          full_o,
  output logic          empty_o
);
  import slx_pkg::*;

  localparam int PW = $clog2(QDEPTH);

  cmd_t          entry_q [QDEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [PW:0]   fill_q, fill_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      fill_d = fill_q + 1'b1;
    end else if (pop_i && !push_i) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

  assign data_o  = entry_q[rd_ptr_q];
  assign full_o  = (fill_q == (PW+1)'(QDEPTH));
  assign empty_o = (fill_q == '0);

endmodule

### hw/rtl/slx_front.sv
module slx_front #(
  parameter int MAX_TEXT  = 16,
  parameter int LINE_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        action_i,
  input  logic [7:0]                  character_i,
  input  slx_pkg::rel_t               rel_i,
  input  logic                        q_full_i,
  output logic                        q_push_o,
  output slx_pkg::cmd_t               q_data_o,
  output logic                        ram_we_o,
  output logic [$clog2(MAX_TEXT):0]   ram_waddr_o,
  output logic [7:0]                  ram_wdata_o
);
  import slx_pkg::*;

  localparam int CW = $clog2(MAX_TEXT + 1);
  localparam int IW = $clog2(MAX_TEXT);

  typedef enum logic [2:0] {
    M_IDLE   = 3'b001,
    M_NAME   = 3'b010,
    M_NUMBER = 3'b100
  } mode_e;

  mode_e                mode_q, mode_d;
  logic [CW-1:0]        count_q, count_d;
  logic                 ovf_q, ovf_d;
  logic                 exit_ok_q, exit_ok_d;
  logic                 int_ok_q, int_ok_d;
  logic [LINE_BITS-1:0] line_q, line_d;
  logic                 bank_q, bank_d;
  logic [1:0]           busy_q, busy_d;

  logic          accept, letter, digit, cont, in_token;
  logic          is_exit, is_int, needs_text, has_op;
  logic          append, start;
  logic [CW-1:0] pos;

  always_comb begin
    letter   = is_letter(character_i);
    digit    = is_digit(character_i);
    accept   = in_valid_i && in_ready_o;
    in_token = (mode_q != M_IDLE);
    cont     = (action_i == ACT_CHAR) &&
               (((mode_q == M_NAME) && (letter || digit)) ||
                ((mode_q == M_NUMBER) && digit));

    // A truncated name is never a keyword.
    is_exit    = (mode_q == M_NAME) && exit_ok_q && !ovf_q && (count_q == CW'(4));
    is_int     = (mode_q == M_NAME) && int_ok_q && !ovf_q && (count_q == CW'(3));
    needs_text = in_token && !is_exit && !is_int;
    has_op     = (action_i == ACT_CHAR) && !cont && is_op(character_i);

    q_data_o.has_tok  = in_token;
    q_data_o.tok_type = is_exit ? TOK_EXIT :
                        is_int  ? TOK_INT  :
                        (mode_q == M_NAME) ? TOK_IDENT : TOK_LITERAL;
    q_data_o.tok_len  = needs_text ? LEN_W'(count_q) : '0;
    q_data_o.trunc    = needs_text && ovf_q;
    q_data_o.bank     = bank_q;
    q_data_o.has_op   = has_op;
    q_data_o.op_type  = op_type(character_i);
    q_data_o.line     = LINE_OUT_W'(line_q);

    q_push_o = accept && !cont && (in_token || has_op);

    mode_d    = mode_q;
    count_d   = count_q;
    ovf_d     = ovf_q;
    exit_ok_d = exit_ok_q;
    int_ok_d  = int_ok_q;
    line_d    = line_q;
    bank_d    = bank_q;
    busy_d    = busy_q;
    append    = 1'b0;
    start     = 1'b0;

    if (rel_i.valid) begin
      busy_d[rel_i.bank] = 1'b0;
    end

    if (accept) begin
      if (action_i == ACT_END) begin
        mode_d  = M_IDLE;
        count_d = '0;
        ovf_d   = 1'b0;
        line_d  = '0;
      end else if (cont) begin
        append = 1'b1;
      end else begin
        mode_d  = M_IDLE;
        count_d = '0;
        ovf_d   = 1'b0;
        if (character_i == CH_NEWLINE) begin
          if (line_q != '1) begin
            line_d = line_q + 1'b1;
          end
        end else if (letter) begin
          mode_d = M_NAME;
          append = 1'b1;
          start  = 1'b1;
        end else if (digit) begin
          mode_d = M_NUMBER;
          append = 1'b1;
          start  = 1'b1;
        end
      end
      // The flushed text stays in its bank until the back end has read it out.
      if (!cont && needs_text) begin
        bank_d         = ~bank_q;
        busy_d[bank_q] = 1'b1;
      end
    end

    pos      = start ? '0 : count_q;
    ram_we_o = 1'b0;
    if (append) begin
      if (pos < CW'(MAX_TEXT)) begin
        ram_we_o = 1'b1;
        count_d  = pos + 1'b1;
      end else begin
        ovf_d = 1'b1;
      end
      exit_ok_d = (start || exit_ok_q) && (pos < CW'(4)) &&
                  (character_i == kw_exit_char(pos[1:0]));
      int_ok_d  = (start || int_ok_q) && (pos < CW'(3)) &&
                  (character_i == kw_int_char(pos[1:0]));
    end
    ram_waddr_o = {bank_d, pos[IW-1:0]};
    ram_wdata_o = character_i;
  end

  assign in_ready_o = !q_full_i && !busy_q[bank_q] &&
                      ((mode_q == M_IDLE) || !busy_q[~bank_q]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= M_IDLE;
      count_q   <= '0;
      ovf_q     <= 1'b0;
      exit_ok_q <= 1'b0;
      int_ok_q  <= 1'b0;
      line_q    <= '0;
      bank_q    <= 1'b0;
      busy_q    <= '0;
    end else begin
      mode_q    <= mode_d;
      count_q   <= count_d;
      ovf_q     <= ovf_d;
      exit_ok_q <= exit_ok_d;
      int_ok_q  <= int_ok_d;
      line_q    <= line_d;
      bank_q    <= bank_d;
      busy_q    <= busy_d;
    end
  end

endmodule

### hw/rtl/slx_back.sv
module slx_back #(
  parameter int MAX_TEXT = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      q_empty_i,
  input  slx_pkg::cmd_t             q_data_i,
  output logic                      q_pop_o,
  output logic                      ram_re_o,
  output logic [$clog2(MAX_TEXT):0] ram_raddr_o,
  input  logic [7:0]                ram_rdata_i,
  output slx_pkg::rel_t             rel_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic                      kind_o,
  output logic [3:0]                token_type_o,
  output logic [15:0]               line_number_o,
  output logic [4:0]                text_length_o,
  output logic                      truncated_o,
  output logic [7:0]                text_char_o,
  output logic                      last_o
);
  import slx_pkg::*;

  localparam int IW = $clog2(MAX_TEXT);

  typedef enum logic [4:0] {
    B_IDLE = 5'b00001,
    B_HEAD = 5'b00010,
    B_READ = 5'b00100,
    B_BYTE = 5'b01000,
    B_OP   = 5'b10000
  } back_state_e;

  back_state_e      state_q, state_d;
  cmd_t             cmd_q, cmd_d;
  logic [LEN_W-1:0] idx_q, idx_d;
  logic [LEN_W-1:0] idx_inc;

  logic             out_valid_q, out_valid_d;
  logic             kind_q, kind_d;
  tok_type_e        type_q, type_d;
  logic [15:0]      line_q, line_d;
  logic [4:0]       len_q, len_d;
  logic             trunc_q, trunc_d;
  logic [7:0]       char_q, char_d;
  logic             last_q, last_d;

  logic out_free, load;

  always_comb begin
    out_free = !out_valid_q || out_ready_i;
    idx_inc  = idx_q + 1'b1;

    state_d  = state_q;
    cmd_d    = cmd_q;
    idx_d    = idx_q;
    kind_d   = kind_q;
    type_d   = type_q;
    line_d   = line_q;
    len_d    = len_q;
    trunc_d  = trunc_q;
    char_d   = char_q;
    last_d   = last_q;
    load     = 1'b0;
    q_pop_o  = 1'b0;
    ram_re_o = 1'b0;
    rel_o    = '{valid: 1'b0, bank: cmd_q.bank};

    case (state_q)
      B_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          cmd_d   = q_data_i;
          state_d = q_data_i.has_tok ? B_HEAD : B_OP;
        end
      end
      B_HEAD: begin
        if (out_free) begin
          load    = 1'b1;
          kind_d  = KIND_HEAD;
          type_d  = cmd_q.tok_type;
          line_d  = cmd_q.line;
          len_d   = 5'(cmd_q.tok_len);
          trunc_d = cmd_q.trunc;
          char_d  = '0;
          last_d  = !cmd_q.has_op && (cmd_q.tok_len == '0);
          idx_d   = '0;
          if (cmd_q.tok_len != '0) begin
            state_d = B_READ;
          end else if (cmd_q.has_op) begin
            state_d = B_OP;
          end else begin
            state_d = B_IDLE;
          end
        end
      end
      B_READ: begin
        ram_re_o = 1'b1;
        state_d  = B_BYTE;
      end
      B_BYTE: begin
        if (out_free) begin
          load   = 1'b1;
          kind_d = KIND_TEXT;
          char_d = ram_rdata_i;
          last_d = (idx_inc == cmd_q.tok_len) && !cmd_q.has_op;
          idx_d  = idx_inc;
          if (idx_inc == cmd_q.tok_len) begin
            rel_o.valid = 1'b1;
            state_d     = cmd_q.has_op ? B_OP : B_IDLE;
          end else begin
            state_d = B_READ;
          end
        end
      end
      B_OP: begin
        if (out_free) begin
          load    = 1'b1;
          kind_d  = KIND_HEAD;
          type_d  = cmd_q.op_type;
          line_d  = cmd_q.line;
          len_d   = '0;
          trunc_d = 1'b0;
          char_d  = '0;
          last_d  = 1'b1;
          state_d = B_IDLE;
        end
      end
      default: begin
        state_d = B_IDLE;
      end
    endcase

    ram_raddr_o = {cmd_q.bank, idx_q[IW-1:0]};

    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    idx_q   <= idx_d;
    kind_q  <= kind_d;
    type_q  <= type_d;
    line_q  <= line_d;
    len_q   <= len_d;
    trunc_q <= trunc_d;
    char_q  <= char_d;
    last_q  <= last_d;
  end

  assign out_valid_o   = out_valid_q;
  assign kind_o        = kind_q;
  assign token_type_o  = type_q;
  assign line_number_o = line_q;
  assign text_length_o = len_q;
  assign truncated_o   = trunc_q;
  assign text_char_o   = char_q;
  assign last_o        = last_q;

endmodule
